[sv/scsi_bch_pkg.sv]
// Shared types and constants for the SCSI block command handler.
package scsi_bch_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgWriteEnable = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgSectorTotal = 1'd1;

  localparam logic [31:0] SectorTotalReset = 32'd65536;

  // Operation codes.
  localparam logic [7:0] OpcTestUnitReady = 8'h00;
  localparam logic [7:0] OpcRequestSense  = 8'h03;
  localparam logic [7:0] OpcFormatUnit    = 8'h04;
  localparam logic [7:0] OpcRead6         = 8'h08;
  localparam logic [7:0] OpcWrite6        = 8'h0A;
  localparam logic [7:0] OpcInquiry       = 8'h12;
  localparam logic [7:0] OpcModeSense6    = 8'h1A;
  localparam logic [7:0] OpcStartStop     = 8'h1B;
  localparam logic [7:0] OpcSendDiag      = 8'h1D;
  localparam logic [7:0] OpcPreventRemove = 8'h1E;
  localparam logic [7:0] OpcReadFmtCap    = 8'h23;
  localparam logic [7:0] OpcReadCapacity  = 8'h25;
  localparam logic [7:0] OpcRead10        = 8'h28;
  localparam logic [7:0] OpcWrite10       = 8'h2A;
  localparam logic [7:0] OpcReportLuns    = 8'hA0;

  // Media request kinds, also used for the pending request.
  localparam logic [1:0] XferNone  = 2'd0;
  localparam logic [1:0] XferRead  = 2'd1;
  localparam logic [1:0] XferErase = 2'd2;
  localparam logic [1:0] XferWrite = 2'd3;

  // Canned reply kinds.
  localparam logic [2:0] RespNone     = 3'd0;
  localparam logic [2:0] RespInquiry  = 3'd1;
  localparam logic [2:0] RespMode     = 3'd2;
  localparam logic [2:0] RespSense    = 3'd3;
  localparam logic [2:0] RespFmtCap   = 3'd4;
  localparam logic [2:0] RespCapacity = 3'd5;
  localparam logic [2:0] RespLuns     = 3'd6;

  // Media outcome codes.
  localparam logic [1:0] OutcomeOk     = 2'd0;
  localparam logic [1:0] OutcomeBusErr = 2'd1;

  // Action codes.
  localparam logic ActCommand = 1'b0;
  localparam logic ActReport  = 1'b1;

  // Sense keys and additional sense codes.
  localparam logic [3:0] SkNone      = 4'h0;
  localparam logic [3:0] SkMedium    = 4'h3;
  localparam logic [3:0] SkIllegal   = 4'h5;
  localparam logic [3:0] SkDataProt  = 4'h7;
  localparam logic [7:0] AscNone     = 8'h00;
  localparam logic [7:0] AscWriteErr = 8'h03;
  localparam logic [7:0] AscReadErr  = 8'h11;
  localparam logic [7:0] AscInvOpc   = 8'h20;
  localparam logic [7:0] AscLbaRange = 8'h21;
  localparam logic [7:0] AscWrProt   = 8'h27;

  localparam logic [15:0] Short6ZeroLen = 16'd256;

  typedef struct packed {
    logic       action;
    logic [7:0] opcode;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
    logic [7:0] b7;
    logic [7:0] b8;
    logic [1:0] outcome;
  } item_t;

  typedef struct packed {
    logic        write_en;
    logic [31:0] sector_total;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  pend_op;
    logic [31:0] pend_lba;
    logic [15:0] pend_cnt;
    logic [3:0]  sense_key;
    logic [7:0]  sense_code;
    logic [7:0]  sense_qual;
  } state_t;

  typedef struct packed {
    logic        done;
    logic        status;
    logic [1:0]  xfer;
    logic [2:0]  resp;
    logic [31:0] lba;
    logic [15:0] cnt;
    logic [3:0]  skey;
    logic [7:0]  scode;
    logic [7:0]  squal;
  } result_t;

endpackage

[sv/scsi_block_command_handler_core.sv]
// Top level of the SCSI block command handler: request and result registers, state.
// Each request (a command descriptor or a media outcome report) yields exactly one
// result. A request is taken into an input register, decoded against the sticky sense
// data and the pending media request, and written to a result register when that
// register is free or being drained; a stalled output can hold it in the input register
// first. Throughput is one request per cycle while the output does not stall, set by
// the single decode stage; a request is still taken while a result waits, and only a
// stalled output with a full input register stalls the input. Configuration writes
// take effect at once and belong to idle periods.
module scsi_block_command_handler_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [scsi_bch_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [scsi_bch_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               action_i,
  input  logic [7:0]                         opcode_i,
  input  logic [7:0]                         cdb_byte1_i,
  input  logic [7:0]                         cdb_byte2_i,
  input  logic [7:0]                         cdb_byte3_i,
  input  logic [7:0]                         cdb_byte4_i,
  input  logic [7:0]                         cdb_byte5_i,
  input  logic [7:0]                         cdb_byte7_i,
  input  logic [7:0]                         cdb_byte8_i,
  input  logic [1:0]                         media_outcome_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               command_done_o,
  output logic                               status_o,
  output logic [1:0]                         transfer_kind_o,
  output logic [2:0]                         response_kind_o,
  output logic [31:0]                        start_lba_o,
  output logic [15:0]                        sector_count_o,
  output logic [3:0]                         sense_key_o,
  output logic [7:0]                         sense_code_o,
  output logic [7:0]                         sense_qualifier_o
);

  scsi_bch_pkg::cfg_t    cfg;
  scsi_bch_pkg::item_t   item_d, item_q;
  scsi_bch_pkg::state_t  st_d, st_q;
  scsi_bch_pkg::result_t res_d, res_q;
  logic                  in_vld_q;
  logic                  out_vld_q;
  logic                  advance;
  logic                  in_take;

  scsi_bch_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  scsi_bch_exec u_exec (
    .item_i (item_q),
    .cfg_i  (cfg),
    .st_i   (st_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  // The decode stage moves whenever the result register is free or being drained.
  assign advance    = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    item_d.action  = action_i;
    item_d.opcode  = opcode_i;
    item_d.b1      = cdb_byte1_i;
    item_d.b2      = cdb_byte2_i;
    item_d.b3      = cdb_byte3_i;
    item_d.b4      = cdb_byte4_i;
    item_d.b5      = cdb_byte5_i;
    item_d.b7      = cdb_byte7_i;
    item_d.b8      = cdb_byte8_i;
    item_d.outcome = media_outcome_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '0;
    end else begin
      // The input register fills on a new request and empties only when it moves on.
      in_vld_q <= in_take || (in_vld_q && !advance);
      if (advance) begin
        out_vld_q <= in_vld_q;
        if (in_vld_q) begin
          st_q <= st_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_d;
    end
    if (advance && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign command_done_o    = res_q.done;
  assign status_o          = res_q.status;
  assign transfer_kind_o   = res_q.xfer;
  assign response_kind_o   = res_q.resp;
  assign start_lba_o       = res_q.lba;
  assign sector_count_o    = res_q.cnt;
  assign sense_key_o       = res_q.skey;
  assign sense_code_o      = res_q.scode;
  assign sense_qualifier_o = res_q.squal;

endmodule

[sv/scsi_bch_cfg.sv]
// Configuration registers: write enable and medium size.
module scsi_bch_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [scsi_bch_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [scsi_bch_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output scsi_bch_pkg::cfg_t                   cfg_o
);

  logic        write_en_q;
  logic [31:0] sector_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_en_q     <= 1'b0;
      sector_total_q <= scsi_bch_pkg::SectorTotalReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        scsi_bch_pkg::CfgWriteEnable: write_en_q     <= cfg_wdata_i[0];
        scsi_bch_pkg::CfgSectorTotal: sector_total_q <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.write_en     = write_en_q;
  assign cfg_o.sector_total = sector_total_q;

endmodule

[sv/scsi_bch_exec.sv]
// Command decode, range check and media outcome handling for one request.
module scsi_bch_exec (
  input  scsi_bch_pkg::item_t   item_i,
  input  scsi_bch_pkg::cfg_t    cfg_i,
  input  scsi_bch_pkg::state_t  st_i,
  output scsi_bch_pkg::state_t  st_o,
  output scsi_bch_pkg::result_t res_o
);

  logic        is_read;
  logic        is_write;
  logic        is_short;
  logic [31:0] lba;
  logic [15:0] cnt;
  logic [32:0] end_sum;
  logic        out_of_range;

  always_comb begin
    is_read  = (item_i.opcode == scsi_bch_pkg::OpcRead6) ||
               (item_i.opcode == scsi_bch_pkg::OpcRead10);
    is_write = (item_i.opcode == scsi_bch_pkg::OpcWrite6) ||
               (item_i.opcode == scsi_bch_pkg::OpcWrite10);
    is_short = (item_i.opcode == scsi_bch_pkg::OpcRead6) ||
               (item_i.opcode == scsi_bch_pkg::OpcWrite6);
    if (is_short) begin
      lba = {11'd0, item_i.b1[4:0], item_i.b2, item_i.b3};
      // A zero length in the short form means 256 blocks.
      cnt = (item_i.b4 == 8'd0) ? scsi_bch_pkg::Short6ZeroLen : {8'd0, item_i.b4};
    end else begin
      lba = {item_i.b2, item_i.b3, item_i.b4, item_i.b5};
      cnt = {item_i.b7, item_i.b8};
    end
    end_sum      = {1'b0, lba} + {17'd0, cnt};
    out_of_range = end_sum > {1'b0, cfg_i.sector_total};
  end

  always_comb begin
    st_o  = st_i;
    res_o = '0;
    if (item_i.action == scsi_bch_pkg::ActReport) begin
      unique case (st_i.pend_op)
        scsi_bch_pkg::XferRead, scsi_bch_pkg::XferWrite: begin
          st_o.pend_op = scsi_bch_pkg::XferNone;
          res_o.done   = 1'b1;
          res_o.status = (item_i.outcome != scsi_bch_pkg::OutcomeOk);
          // A bus error leaves the sense data as it was.
          if (item_i.outcome != scsi_bch_pkg::OutcomeOk &&
              item_i.outcome != scsi_bch_pkg::OutcomeBusErr) begin
            st_o.sense_key  = scsi_bch_pkg::SkMedium;
            st_o.sense_code = (st_i.pend_op == scsi_bch_pkg::XferRead) ?
                              scsi_bch_pkg::AscReadErr : scsi_bch_pkg::AscWriteErr;
            st_o.sense_qual = scsi_bch_pkg::AscNone;
          end
        end
        scsi_bch_pkg::XferErase: begin
          if (item_i.outcome == scsi_bch_pkg::OutcomeOk) begin
            st_o.pend_op = scsi_bch_pkg::XferWrite;
            res_o.xfer   = scsi_bch_pkg::XferWrite;
          end else begin
            st_o.pend_op    = scsi_bch_pkg::XferNone;
            st_o.sense_key  = scsi_bch_pkg::SkMedium;
            st_o.sense_code = scsi_bch_pkg::AscWriteErr;
            st_o.sense_qual = scsi_bch_pkg::AscNone;
            res_o.done      = 1'b1;
            res_o.status    = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      // A new command abandons whatever request was in flight.
      st_o.pend_op = scsi_bch_pkg::XferNone;
      if (is_read || is_write) begin
        if (is_write && !cfg_i.write_en) begin
          st_o.sense_key  = scsi_bch_pkg::SkDataProt;
          st_o.sense_code = scsi_bch_pkg::AscWrProt;
          st_o.sense_qual = scsi_bch_pkg::AscNone;
          res_o.done      = 1'b1;
          res_o.status    = 1'b1;
        end else if (out_of_range) begin
          st_o.sense_key  = scsi_bch_pkg::SkIllegal;
          st_o.sense_code = scsi_bch_pkg::AscLbaRange;
          st_o.sense_qual = scsi_bch_pkg::AscNone;
          res_o.done      = 1'b1;
          res_o.status    = 1'b1;
        end else begin
          st_o.pend_op  = is_read ? scsi_bch_pkg::XferRead : scsi_bch_pkg::XferErase;
          st_o.pend_lba = lba;
          st_o.pend_cnt = cnt;
          res_o.xfer    = st_o.pend_op;
        end
      end else begin
        res_o.done = 1'b1;
        unique case (item_i.opcode)
          scsi_bch_pkg::OpcTestUnitReady, scsi_bch_pkg::OpcStartStop,
          scsi_bch_pkg::OpcSendDiag, scsi_bch_pkg::OpcPreventRemove: ;
          scsi_bch_pkg::OpcRequestSense: begin
            res_o.resp      = scsi_bch_pkg::RespSense;
            res_o.skey      = st_i.sense_key;
            res_o.scode     = st_i.sense_code;
            res_o.squal     = st_i.sense_qual;
            st_o.sense_key  = scsi_bch_pkg::SkNone;
            st_o.sense_code = scsi_bch_pkg::AscNone;
            st_o.sense_qual = scsi_bch_pkg::AscNone;
          end
          scsi_bch_pkg::OpcFormatUnit: begin
            if (!cfg_i.write_en) begin
              st_o.sense_key  = scsi_bch_pkg::SkDataProt;
              st_o.sense_code = scsi_bch_pkg::AscWrProt;
              st_o.sense_qual = scsi_bch_pkg::AscNone;
              res_o.status    = 1'b1;
            end
          end
          scsi_bch_pkg::OpcInquiry:      res_o.resp = scsi_bch_pkg::RespInquiry;
          scsi_bch_pkg::OpcModeSense6:   res_o.resp = scsi_bch_pkg::RespMode;
          scsi_bch_pkg::OpcReadFmtCap:   res_o.resp = scsi_bch_pkg::RespFmtCap;
          scsi_bch_pkg::OpcReadCapacity: res_o.resp = scsi_bch_pkg::RespCapacity;
          scsi_bch_pkg::OpcReportLuns:   res_o.resp = scsi_bch_pkg::RespLuns;
          default: begin
            st_o.sense_key  = scsi_bch_pkg::SkIllegal;
            st_o.sense_code = scsi_bch_pkg::AscInvOpc;
            st_o.sense_qual = scsi_bch_pkg::AscNone;
            res_o.status    = 1'b1;
          end
        endcase
      end
    end
    if (res_o.xfer != scsi_bch_pkg::XferNone) begin
      res_o.lba = st_o.pend_lba;
      res_o.cnt = st_o.pend_cnt;
    end
  end

endmodule

[sv/scsi_bch_chk.sv]
// Port-level checks for the SCSI block command handler, bound to the top level.
module scsi_bch_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        command_done_o,
  input logic        status_o,
  input logic [1:0]  transfer_kind_o,
  input logic [2:0]  response_kind_o,
  input logic [31:0] start_lba_o,
  input logic [15:0] sector_count_o,
  input logic [3:0]  sense_key_o,
  input logic [7:0]  sense_code_o,
  input logic [7:0]  sense_qualifier_o
);

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(command_done_o) &&
      $stable(status_o) && $stable(transfer_kind_o) && $stable(start_lba_o) &&
      $stable(sector_count_o) && $stable(sense_key_o))
    else $error("stalled result changed");

  // A failure status only comes with a finished command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> command_done_o)
    else $error("check condition without command done");

  // Issuing a media request never finishes the command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (transfer_kind_o != scsi_bch_pkg::XferNone) |->
      !command_done_o && (response_kind_o == scsi_bch_pkg::RespNone))
    else $error("media request on a finished command");

  // Without a media request the address and count read as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (transfer_kind_o == scsi_bch_pkg::XferNone) |->
      (start_lba_o == 32'd0) && (sector_count_o == 16'd0))
    else $error("stray address or count");

  // Sense data appears only in a sense reply.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (response_kind_o != scsi_bch_pkg::RespSense) |->
      (sense_key_o == 4'd0) && (sense_code_o == 8'd0) && (sense_qualifier_o == 8'd0))
    else $error("sense data outside a sense reply");

endmodule

bind scsi_block_command_handler_core scsi_bch_chk u_scsi_bch_chk (.*);
